/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define Q2R_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define Q2R_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/q2r_pkg.sv */
`timescale 1ns / 1ps

package q2r_pkg;

  localparam int IN_W   = 16;
  localparam int PROD_W = 32;
  localparam int D_W    = 33;                // sum of four squares, up to 2^32
  localparam int NUM_W  = 34;                // doubled cross terms, up to +-2^32
  localparam int DEN_W  = D_W + 1;           // twice the squared length
  localparam int QUO_W  = 15;                // quotient never exceeds 2^14
  localparam int REM_W  = NUM_W + QUO_W - 1; // (mag << 15) + d
  localparam int OUT_W  = 16;
  localparam int N_ENT  = 9;

  localparam logic signed [OUT_W-1:0] Q14_ONE = 16'sd16384;

  // matrix entry slots, row major
  localparam int E00 = 0;
  localparam int E01 = 1;
  localparam int E02 = 2;
  localparam int E10 = 3;
  localparam int E11 = 4;
  localparam int E12 = 5;
  localparam int E20 = 6;
  localparam int E21 = 7;
  localparam int E22 = 8;

  // payload carried through the divider stages
  typedef struct packed {
    logic [N_ENT-1:0][REM_W-1:0] rem;
    logic [N_ENT-1:0][QUO_W-1:0] quo;
    logic [N_ENT-1:0]            neg;
    logic [DEN_W-1:0]            den;
    logic                        zero;
  } div_t;

endpackage

/* design/q2r_div_stage.sv */
`timescale 1ns / 1ps

// one restoring division step for all nine entries, registered
module q2r_div_stage #(
  parameter int BIT = 14
) (
  input  logic           clk,
  input  logic           en,
  input  q2r_pkg::div_t  d_in,
  output q2r_pkg::div_t  d_out
);

  q2r_pkg::div_t d_next;
  logic [q2r_pkg::REM_W-1:0] dsh;

  always_comb begin
    d_next = d_in;
    dsh    = q2r_pkg::REM_W'(d_in.den) << BIT;
    for (int k = 0; k < q2r_pkg::N_ENT; k++) begin
      if (d_in.rem[k] >= dsh) begin
        d_next.rem[k]      = d_in.rem[k] - dsh;
        d_next.quo[k][BIT] = 1'b1;
      end else begin
        d_next.quo[k][BIT] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

/* design/quaternion_to_rotation_matrix_unit.sv */
// quaternion (q1.15) to 3x3 rotation matrix (q2.14), normalised by the squared length
// throughput: one beat per cycle while out_ready is high; a product stage, a sum
//   stage, a divider set-up stage, fifteen one-bit divider stages and an output stage, each stage stalls on its own
// reset: synchronous, clears the stage valid bits only; data registers are not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quaternion_to_rotation_matrix_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [q2r_pkg::IN_W-1:0]       quat_x,
  input  logic signed [q2r_pkg::IN_W-1:0]       quat_y,
  input  logic signed [q2r_pkg::IN_W-1:0]       quat_z,
  input  logic signed [q2r_pkg::IN_W-1:0]       quat_w,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [q2r_pkg::OUT_W-1:0]      m00,
  output logic signed [q2r_pkg::OUT_W-1:0]      m01,
  output logic signed [q2r_pkg::OUT_W-1:0]      m02,
  output logic signed [q2r_pkg::OUT_W-1:0]      m10,
  output logic signed [q2r_pkg::OUT_W-1:0]      m11,
  output logic signed [q2r_pkg::OUT_W-1:0]      m12,
  output logic signed [q2r_pkg::OUT_W-1:0]      m20,
  output logic signed [q2r_pkg::OUT_W-1:0]      m21,
  output logic signed [q2r_pkg::OUT_W-1:0]      m22,
  output logic                                  zero_length
);

  // stage map: 0 products, 1 sums, 2 divider set-up, 3..17 divider bits, 18 output
  localparam int DIV0 = 3;
  localparam int LAST = DIV0 + q2r_pkg::QUO_W;

  logic [LAST:0] vld;
  logic [LAST:0] adv;

  // elastic handshake: a stage takes a new beat when empty or when it moves on
  always_comb begin
    adv[LAST] = !vld[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k + 1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  // stage 0: the ten distinct products
  logic signed [q2r_pkg::PROD_W-1:0] p_xx, p_yy, p_zz, p_ww;
  logic signed [q2r_pkg::PROD_W-1:0] p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  logic signed [q2r_pkg::PROD_W-1:0] w_x, w_y, w_z, w_w;

  // sign-extended to the product width before multiplying
  assign w_x = q2r_pkg::PROD_W'(quat_x);
  assign w_y = q2r_pkg::PROD_W'(quat_y);
  assign w_z = q2r_pkg::PROD_W'(quat_z);
  assign w_w = q2r_pkg::PROD_W'(quat_w);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_xx <= w_x * w_x;
      p_yy <= w_y * w_y;
      p_zz <= w_z * w_z;
      p_ww <= w_w * w_w;
      p_xy <= w_x * w_y;
      p_xz <= w_x * w_z;
      p_yz <= w_y * w_z;
      p_wx <= w_w * w_x;
      p_wy <= w_w * w_y;
      p_wz <= w_w * w_z;
    end
  end

  // stage 1: squared length and the nine numerators
  logic [q2r_pkg::D_W-1:0]          sq_len;
  logic signed [q2r_pkg::NUM_W-1:0] num [q2r_pkg::N_ENT];

  logic signed [q2r_pkg::NUM_W-1:0] e_xx, e_yy, e_zz, e_ww;
  logic signed [q2r_pkg::NUM_W-1:0] e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;

  assign e_xx = q2r_pkg::NUM_W'(p_xx);
  assign e_yy = q2r_pkg::NUM_W'(p_yy);
  assign e_zz = q2r_pkg::NUM_W'(p_zz);
  assign e_ww = q2r_pkg::NUM_W'(p_ww);
  assign e_xy = q2r_pkg::NUM_W'(p_xy);
  assign e_xz = q2r_pkg::NUM_W'(p_xz);
  assign e_yz = q2r_pkg::NUM_W'(p_yz);
  assign e_wx = q2r_pkg::NUM_W'(p_wx);
  assign e_wy = q2r_pkg::NUM_W'(p_wy);
  assign e_wz = q2r_pkg::NUM_W'(p_wz);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      // squares are never negative, so the unsigned view is exact
      sq_len <= q2r_pkg::D_W'($unsigned(p_xx)) + q2r_pkg::D_W'($unsigned(p_yy))
              + q2r_pkg::D_W'($unsigned(p_zz)) + q2r_pkg::D_W'($unsigned(p_ww));
      num[q2r_pkg::E00] <= e_xx + e_ww - e_yy - e_zz;
      num[q2r_pkg::E11] <= e_yy + e_ww - e_xx - e_zz;
      num[q2r_pkg::E22] <= e_zz + e_ww - e_xx - e_yy;
      num[q2r_pkg::E01] <= (e_xy + e_wz) <<< 1;
      num[q2r_pkg::E10] <= (e_xy - e_wz) <<< 1;
      num[q2r_pkg::E02] <= (e_xz - e_wy) <<< 1;
      num[q2r_pkg::E20] <= (e_xz + e_wy) <<< 1;
      num[q2r_pkg::E12] <= (e_yz + e_wx) <<< 1;
      num[q2r_pkg::E21] <= (e_yz - e_wx) <<< 1;
    end
  end

  // stage 2: sign and magnitude split; the dividend carries the rounding half,
  // so q = floor(((|n| << 15) + d) / 2d) rounds ties away from zero
  q2r_pkg::div_t divq [q2r_pkg::QUO_W + 1];
  q2r_pkg::div_t div_init;
  logic [q2r_pkg::NUM_W-1:0] mag [q2r_pkg::N_ENT];

  always_comb begin
    div_init      = '0;
    div_init.den  = {sq_len, 1'b0};
    div_init.zero = (sq_len == '0);
    for (int k = 0; k < q2r_pkg::N_ENT; k++) begin
      div_init.neg[k] = num[k][q2r_pkg::NUM_W-1];
      mag[k]          = div_init.neg[k] ? $unsigned(-num[k]) : $unsigned(num[k]);
      div_init.rem[k] = (q2r_pkg::REM_W'(mag[k]) << q2r_pkg::QUO_W)
                      + q2r_pkg::REM_W'(sq_len);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      divq[0] <= div_init;
    end
  end

  // stages 3..17: one quotient bit per stage, msb first
  for (genvar j = 0; j < q2r_pkg::QUO_W; j++) begin : g_div
    q2r_div_stage #(
      .BIT (q2r_pkg::QUO_W - 1 - j)
    ) u_stage (
      .clk   (clk),
      .en    (adv[DIV0 + j]),
      .d_in  (divq[j]),
      .d_out (divq[j + 1])
    );
  end

  // stage 18: apply sign, identity on a zero-length quaternion
  // every ratio lies within +-1, so the quotient fits and no clamp is needed
  logic signed [q2r_pkg::OUT_W-1:0] mres [q2r_pkg::N_ENT];
  logic signed [q2r_pkg::OUT_W-1:0] mval [q2r_pkg::N_ENT];
  logic                             zl;
  q2r_pkg::div_t                    dfin;

  assign dfin = divq[q2r_pkg::QUO_W];

  always_comb begin
    for (int k = 0; k < q2r_pkg::N_ENT; k++) begin
      if (dfin.zero) begin
        mval[k] = '0;
      end else if (dfin.neg[k]) begin
        mval[k] = -$signed({1'b0, dfin.quo[k]});
      end else begin
        mval[k] = $signed({1'b0, dfin.quo[k]});
      end
    end
    if (dfin.zero) begin
      mval[q2r_pkg::E00] = q2r_pkg::Q14_ONE;
      mval[q2r_pkg::E11] = q2r_pkg::Q14_ONE;
      mval[q2r_pkg::E22] = q2r_pkg::Q14_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      mres <= mval;
      zl   <= dfin.zero;
    end
  end

  assign m00         = mres[q2r_pkg::E00];
  assign m01         = mres[q2r_pkg::E01];
  assign m02         = mres[q2r_pkg::E02];
  assign m10         = mres[q2r_pkg::E10];
  assign m11         = mres[q2r_pkg::E11];
  assign m12         = mres[q2r_pkg::E12];
  assign m20         = mres[q2r_pkg::E20];
  assign m21         = mres[q2r_pkg::E21];
  assign m22         = mres[q2r_pkg::E22];
  assign zero_length = zl;

  // checks
  logic ident_ok;
  logic diag_ok;

  // result port holds the identity
  assign ident_ok = m00 == q2r_pkg::Q14_ONE && m11 == q2r_pkg::Q14_ONE
                 && m22 == q2r_pkg::Q14_ONE && m01 == 16'sd0 && m02 == 16'sd0
                 && m10 == 16'sd0 && m12 == 16'sd0 && m20 == 16'sd0 && m21 == 16'sd0;
  // every diagonal entry within +-1.0
  assign diag_ok  = m00 >= -16'sd16384 && m00 <= 16'sd16384
                 && m11 >= -16'sd16384 && m11 <= 16'sd16384
                 && m22 >= -16'sd16384 && m22 <= 16'sd16384;

  `Q2R_ASSERT_IMPLY(a_identity, clk, rst, out_valid && zero_length, ident_ok, "zero-length beat is not the identity")
  `Q2R_ASSERT_IMPLY(a_diag_range, clk, rst, out_valid && !zero_length, diag_ok, "diagonal entry outside unit range")
  `Q2R_ASSERT_NEXT(a_enter, clk, rst, in_valid && in_ready, vld[0], "accepted beat did not enter the pipe")
  `Q2R_ASSERT_NEXT(a_hold, clk, rst, vld[LAST] && vld[LAST-1] && !out_ready, vld[LAST-1], "beat lost behind a stalled output")

endmodule
